@@ hdl/sht1x_sensor_bus_master_macros.svh @@
// assertion macros for the sensor bus master
`ifndef SHT1X_SENSOR_BUS_MASTER_MACROS_SVH
`define SHT1X_SENSOR_BUS_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SHT1X_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sht1x assertion failed");

// next-cycle implication, checked out of reset
`define SHT1X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sht1x assertion failed");

`else

`define SHT1X_ASSERT_NOW(label, ante, cons)
`define SHT1X_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/sht1x_pkg.sv @@
// types, codes and constants shared by the sensor bus master
`timescale 1ns / 1ps

package sht1x_pkg;

    localparam int WAIT_TIMER_BITS = 24;
    localparam int HALF_BITS       = 16;
    localparam int WAIT_CFG_BITS   = 24;
    localparam int CFG_DATA_BITS   = 24;

    localparam logic [HALF_BITS-1:0]     HALF_RESET = 16'd2;
    localparam logic [WAIT_CFG_BITS-1:0] WAIT_RESET = 24'd320000;

    // register indexes
    localparam logic REG_HALF_PERIOD  = 1'b0;
    localparam logic REG_MEASURE_WAIT = 1'b1;

    // operation codes
    localparam logic [2:0] OP_CONN_RESET = 3'd0;
    localparam logic [2:0] OP_TEMP       = 3'd1;
    localparam logic [2:0] OP_HUMID      = 3'd2;
    localparam logic [2:0] OP_STAT_RD    = 3'd3;
    localparam logic [2:0] OP_STAT_WR    = 3'd4;
    localparam logic [2:0] OP_SOFT_RST   = 3'd5;

    // sensor command bytes
    localparam logic [7:0] CMD_NONE    = 8'h00;
    localparam logic [7:0] CMD_TEMP    = 8'h03;
    localparam logic [7:0] CMD_HUMID   = 8'h05;
    localparam logic [7:0] CMD_STAT_RD = 8'h07;
    localparam logic [7:0] CMD_STAT_WR = 8'h06;
    localparam logic [7:0] CMD_SOFT    = 8'h1E;

    localparam logic [3:0] CLOCKS_CONN_RESET = 4'd9;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
    localparam logic [1:0] ERR_MAX           = 2'd3;

    typedef enum logic [18:0] {
        PH_IDLE   = 19'h00001,
        PH_CLK_HI = 19'h00002,
        PH_CLK_LO = 19'h00004,
        PH_ST0    = 19'h00008,
        PH_ST1    = 19'h00010,
        PH_ST2    = 19'h00020,
        PH_ST3    = 19'h00040,
        PH_ST4    = 19'h00080,
        PH_ST5    = 19'h00100,
        PH_WB_LO  = 19'h00200,
        PH_WB_HI  = 19'h00400,
        PH_WA_LO  = 19'h00800,
        PH_WA_HI  = 19'h01000,
        PH_WAIT   = 19'h02000,
        PH_RB_LO  = 19'h04000,
        PH_RB_HI  = 19'h08000,
        PH_RA_LO  = 19'h10000,
        PH_RA_HI  = 19'h20000,
        PH_RA_END = 19'h40000
    } phase_t;

    typedef struct packed {
        logic        sck_level;
        logic        data_release;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic [7:0]  checksum_byte;
        logic [1:0]  error_count;
    } res_t;

    function automatic logic [7:0] cmd_code(input logic [2:0] op);
        logic [7:0] code;
        unique case (op)
            OP_TEMP:     code = CMD_TEMP;
            OP_HUMID:    code = CMD_HUMID;
            OP_STAT_RD:  code = CMD_STAT_RD;
            OP_STAT_WR:  code = CMD_STAT_WR;
            OP_SOFT_RST: code = CMD_SOFT;
            default:     code = CMD_NONE;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/sht1x_seq.sv @@
// pin-level sequencer: one tick of the bus per request
`timescale 1ns / 1ps

module sht1x_seq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic                                  func,
    input  logic [2:0]                            op,
    input  logic [7:0]                            write_value,
    input  logic                                  data_level,
    input  logic [sht1x_pkg::HALF_BITS-1:0]       half_period,
    input  logic [sht1x_pkg::WAIT_CFG_BITS-1:0]   measure_wait,
    output sht1x_pkg::res_t                       res
);
    import sht1x_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [2:0]                 aop_reg, aop_next;
    logic [WAIT_TIMER_BITS-1:0] dcnt_reg, dcnt_next;
    logic [3:0]                 bcnt_reg, bcnt_next;
    logic [1:0]                 bidx_reg, bidx_next;
    logic [7:0]                 shift_reg, shift_next;
    logic [15:0]                value_reg, value_next;
    logic [7:0]                 csum_reg, csum_next;
    logic [1:0]                 err_reg, err_next;

    logic                       sck;
    logic                       rel;
    logic                       busy;
    logic                       done;
    logic [WAIT_TIMER_BITS-1:0] seg_len;
    logic [WAIT_TIMER_BITS:0]   cnt;
    logic [7:0]                 rd_byte;
    logic [3:0]                 bcnt_inc;

    function automatic logic last_read(input logic [2:0] aop, input logic [1:0] bidx);
        logic r;
        if (aop == OP_STAT_RD)
            r = (bidx >= 2'd1);
        else
            r = (bidx >= 2'd2);
        return r;
    endfunction

    function automatic logic [1:0] err_add(input logic [1:0] e);
        logic [1:0] r;
        r = (e == ERR_MAX) ? ERR_MAX : e + 2'd1;
        return r;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        aop_next   = aop_reg;
        dcnt_next  = dcnt_reg;
        bcnt_next  = bcnt_reg;
        bidx_next  = bidx_reg;
        shift_next = shift_reg;
        value_next = value_reg;
        csum_next  = csum_reg;
        err_next   = err_reg;
        sck        = 1'b0;
        rel        = 1'b1;
        busy       = 1'b0;
        done       = 1'b0;
        seg_len    = '0;
        cnt        = '0;
        rd_byte    = '0;
        bcnt_inc   = '0;

        if (accept)
        begin
            // command start while idle
            if (phase_reg == PH_IDLE && func && op <= OP_SOFT_RST)
            begin
                aop_next  = op;
                err_next  = '0;
                dcnt_next = '0;
                bcnt_next = '0;
                bidx_next = '0;
                if (op == OP_TEMP || op == OP_HUMID || op == OP_STAT_RD)
                    value_next = '0;
                if (op == OP_STAT_WR)
                    value_next = {8'd0, write_value};
                if (op == OP_CONN_RESET || op == OP_SOFT_RST)
                    phase_next = PH_CLK_HI;
                else
                    phase_next = PH_ST0;
            end

            if (phase_next != PH_IDLE)
            begin
                busy = 1'b1;
                unique case (phase_next)
                    PH_CLK_HI: begin sck = 1'b1; rel = 1'b1; end
                    PH_ST1:    begin sck = 1'b1; rel = 1'b1; end
                    PH_ST2:    begin sck = 1'b1; rel = 1'b0; end
                    PH_ST3:    begin sck = 1'b0; rel = 1'b0; end
                    PH_ST4:    begin sck = 1'b1; rel = 1'b0; end
                    PH_ST5:    begin sck = 1'b1; rel = 1'b1; end
                    PH_WB_LO:  begin sck = 1'b0; rel = shift_next[7]; end
                    PH_WB_HI:  begin sck = 1'b1; rel = shift_next[7]; end
                    PH_WA_HI:  begin sck = 1'b1; rel = 1'b1; end
                    PH_RB_HI:  begin sck = 1'b1; rel = 1'b1; end
                    PH_RA_LO:  begin sck = 1'b0; rel = last_read(aop_next, bidx_next); end
                    PH_RA_HI:  begin sck = 1'b1; rel = last_read(aop_next, bidx_next); end
                    PH_RA_END: begin sck = 1'b0; rel = last_read(aop_next, bidx_next); end
                    default:   begin sck = 1'b0; rel = 1'b1; end
                endcase

                if (phase_next == PH_WAIT)
                    seg_len = WAIT_TIMER_BITS'(measure_wait);
                else
                    seg_len = WAIT_TIMER_BITS'(half_period);
                cnt      = {1'b0, dcnt_next} + (WAIT_TIMER_BITS + 1)'(1);
                bcnt_inc = bcnt_next + 4'd1;
                rd_byte  = {shift_next[6:0], data_level};

                if (cnt >= {1'b0, seg_len})
                begin
                    dcnt_next = '0;
                    // end of segment
                    unique case (phase_next)
                        PH_CLK_HI: phase_next = PH_CLK_LO;
                        PH_CLK_LO:
                        begin
                            if (bcnt_inc >= CLOCKS_CONN_RESET)
                            begin
                                bcnt_next  = '0;
                                phase_next = PH_ST0;
                            end
                            else
                            begin
                                bcnt_next  = bcnt_inc;
                                phase_next = PH_CLK_HI;
                            end
                        end
                        PH_ST0: phase_next = PH_ST1;
                        PH_ST1: phase_next = PH_ST2;
                        PH_ST2: phase_next = PH_ST3;
                        PH_ST3: phase_next = PH_ST4;
                        PH_ST4: phase_next = PH_ST5;
                        PH_ST5:
                        begin
                            if (aop_next == OP_CONN_RESET)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bidx_next  = '0;
                                shift_next = cmd_code(aop_next);
                                bcnt_next  = '0;
                                phase_next = PH_WB_LO;
                            end
                        end
                        PH_WB_LO: phase_next = PH_WB_HI;
                        PH_WB_HI:
                        begin
                            shift_next = {shift_next[6:0], 1'b0};
                            bcnt_next  = bcnt_inc;
                            phase_next = (bcnt_inc >= BITS_PER_BYTE) ? PH_WA_LO : PH_WB_LO;
                        end
                        PH_WA_LO: phase_next = PH_WA_HI;
                        PH_WA_HI:
                        begin
                            if (data_level)
                                err_next = err_add(err_next);
                            if (aop_next == OP_STAT_WR && bidx_next == 2'd0)
                            begin
                                bidx_next  = 2'd1;
                                shift_next = value_next[7:0];
                                bcnt_next  = '0;
                                phase_next = PH_WB_LO;
                            end
                            else if (aop_next == OP_TEMP || aop_next == OP_HUMID)
                                phase_next = PH_WAIT;
                            else if (aop_next == OP_STAT_RD)
                            begin
                                bidx_next  = '0;
                                shift_next = '0;
                                bcnt_next  = '0;
                                phase_next = PH_RB_LO;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                        PH_WAIT:
                        begin
                            // line still high after the wait: conversion timeout
                            if (data_level)
                                err_next = err_add(err_next);
                            bidx_next  = '0;
                            shift_next = '0;
                            bcnt_next  = '0;
                            phase_next = PH_RB_LO;
                        end
                        PH_RB_LO: phase_next = PH_RB_HI;
                        PH_RB_HI:
                        begin
                            shift_next = rd_byte;
                            bcnt_next  = bcnt_inc;
                            if (bcnt_inc >= BITS_PER_BYTE)
                            begin
                                if (last_read(aop_next, bidx_next))
                                    csum_next = rd_byte;
                                else
                                    value_next = {value_next[7:0], rd_byte};
                                phase_next = PH_RA_LO;
                            end
                            else
                                phase_next = PH_RB_LO;
                        end
                        PH_RA_LO: phase_next = PH_RA_HI;
                        PH_RA_HI: phase_next = PH_RA_END;
                        PH_RA_END:
                        begin
                            if (last_read(aop_next, bidx_next))
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                bidx_next  = bidx_next + 2'd1;
                                shift_next = '0;
                                bcnt_next  = '0;
                                phase_next = PH_RB_LO;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                else
                    dcnt_next = cnt[WAIT_TIMER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            aop_reg   <= '0;
            dcnt_reg  <= '0;
            bcnt_reg  <= '0;
            bidx_reg  <= '0;
            shift_reg <= '0;
            value_reg <= '0;
            csum_reg  <= '0;
            err_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            aop_reg   <= aop_next;
            dcnt_reg  <= dcnt_next;
            bcnt_reg  <= bcnt_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
            value_reg <= value_next;
            csum_reg  <= csum_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        res.sck_level     = sck;
        res.data_release  = rel;
        res.busy_res      = busy;
        res.done_res      = done;
        res.read_value    = value_next;
        res.checksum_byte = csum_next;
        res.error_count   = err_next;
    end

endmodule

@@ hdl/sht1x_sensor_bus_master.sv @@
// top level of the two-wire sensor bus master: config, sequencer, output buffer
//
// channel   direction  handshake            payload
// in        request    in_valid / in_ready  func, op, write_value, data_level
// out       result     out_valid/out_ready  sck_level .. error_count
// cfg       write      cfg_we               cfg_index, cfg_data
//
// one request per clock while in_ready is high; its result is registered in the output register or the skid entry
// the sequencer state advances in the same cycle the request is taken
// a skid entry takes one request during an output stall; in_ready is low while it is full
// reset is asynchronous, active low; phase returns to idle, registers to defaults
`timescale 1ns / 1ps
`include "sht1x_sensor_bus_master_macros.svh"

module sht1x_sensor_bus_master (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 func,
    input  logic [2:0]                           op,
    input  logic [7:0]                           write_value,
    input  logic                                 data_level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 sck_level,
    output logic                                 data_release,
    output logic                                 busy_res,
    output logic                                 done_res,
    output logic [15:0]                          read_value,
    output logic [7:0]                           checksum_byte,
    output logic [1:0]                           error_count,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [sht1x_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import sht1x_pkg::*;

    logic [HALF_BITS-1:0]     half_reg;
    logic [WAIT_CFG_BITS-1:0] wait_reg;
    logic                     accept;
    res_t                     step_res;
    res_t                     out_data_reg;
    res_t                     skid_data_reg;
    logic                     out_valid_reg;
    logic                     skid_valid_reg;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
            wait_reg <= WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_PERIOD:  half_reg <= cfg_data[HALF_BITS-1:0];
                REG_MEASURE_WAIT: wait_reg <= cfg_data[WAIT_CFG_BITS-1:0];
                default:          half_reg <= half_reg;
            endcase
        end
    end

    sht1x_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .func         (func),
        .op           (op),
        .write_value  (write_value),
        .data_level   (data_level),
        .half_period  (half_reg),
        .measure_wait (wait_reg),
        .res          (step_res)
    );

    // output register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= step_res;
        end
        else if (accept)
            skid_data_reg <= step_res;
    end

    assign out_valid     = out_valid_reg;
    assign sck_level     = out_data_reg.sck_level;
    assign data_release  = out_data_reg.data_release;
    assign busy_res      = out_data_reg.busy_res;
    assign done_res      = out_data_reg.done_res;
    assign read_value    = out_data_reg.read_value;
    assign checksum_byte = out_data_reg.checksum_byte;
    assign error_count   = out_data_reg.error_count;

    `SHT1X_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `SHT1X_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid_reg && !out_ready, skid_valid_reg)
    `SHT1X_ASSERT_NOW(a_done_while_busy, out_valid_reg && done_res, busy_res)

endmodule

@@ tb/sht1x_sensor_bus_master_test.sv @@
// self-checking testbench for the two-wire sensor bus master
`timescale 1ns / 1ps

module sht1x_sensor_bus_master_test;
    import sht1x_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_LIMIT = 40;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [5:0] ALL_OPS    = 6'b111111;
    localparam logic [5:0] NO_MEASURE = 6'b111001;
    localparam logic [5:0] NO_OPS     = 6'b000000;

    typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_t;

    typedef struct packed {
        logic       func;
        logic [2:0] op;
        logic [7:0] write_value;
        logic       data_level;
        logic       drain_first;
    } tick_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     func = 1'b0;
    logic [2:0]               op = OP_CONN_RESET;
    logic [7:0]               write_value = 8'h00;
    logic                     data_level = 1'b1;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     sck_level;
    logic                     data_release;
    logic                     busy_res;
    logic                     done_res;
    logic [15:0]              read_value;
    logic [7:0]               checksum_byte;
    logic [1:0]               error_count;
    logic                     cfg_we = 1'b0;
    logic                     cfg_index = REG_HALF_PERIOD;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // sequencer prediction state
    logic [HALF_BITS-1:0]       half_ticks;
    logic [WAIT_CFG_BITS-1:0]   wait_ticks;
    phase_t                     seq_phase;
    logic [2:0]                 seq_op;
    logic [WAIT_TIMER_BITS-1:0] seg_count;
    logic [3:0]                 bit_count;
    logic [1:0]                 byte_count;
    logic [7:0]                 shift_reg;
    logic [15:0]                word_reg;
    logic [7:0]                 crc_reg;
    logic [1:0]                 err_reg;

    tick_t tick_queue[$];
    res_t  pin_forecast[$];
    int    ticks_queued = 0;
    int    pins_checked = 0;
    int    mismatch_count = 0;
    int    cycle_count = 0;

    tick_t shown_tick;
    int    gap_left = 0;
    logic  gap_burst = 1'b0;
    int    stall_left = 0;
    logic  stall_burst = 1'b0;
    res_t  seen_pins;
    res_t  want_pins;

    sht1x_sensor_bus_master i_dut (.*);

    always #4 clk = ~clk;

    function automatic logic on_last_byte();
        if (seq_op == OP_STAT_RD)
            return byte_count >= 2'd1;
        return byte_count >= 2'd2;
    endfunction

    function automatic void count_error();
        if (err_reg != ERR_MAX)
            err_reg = err_reg + 2'd1;
    endfunction

    function automatic void load_read();
        shift_reg = 8'h00;
        bit_count = 4'd0;
        seq_phase = PH_RB_LO;
    endfunction

    function automatic void load_write(input logic [7:0] value);
        shift_reg = value;
        bit_count = 4'd0;
        seq_phase = PH_WB_LO;
    endfunction

    // one tick of the pin sequencer: pin levels and read-back after the tick
    function automatic res_t step_sequencer(input tick_t t);
        res_t                       r;
        logic [WAIT_TIMER_BITS:0]   next_count;
        logic [WAIT_TIMER_BITS-1:0] seg_len;
        r = '0;
        r.data_release = 1'b1;
        if (seq_phase == PH_IDLE && t.func && t.op <= OP_SOFT_RST)
        begin
            seq_op = t.op;
            err_reg = 2'd0;
            seg_count = '0;
            bit_count = 4'd0;
            byte_count = 2'd0;
            if (t.op == OP_TEMP || t.op == OP_HUMID || t.op == OP_STAT_RD)
                word_reg = 16'h0000;
            if (t.op == OP_STAT_WR)
                word_reg = {8'h00, t.write_value};
            if (t.op == OP_CONN_RESET || t.op == OP_SOFT_RST)
                seq_phase = PH_CLK_HI;
            else
                seq_phase = PH_ST0;
        end
        if (seq_phase != PH_IDLE)
        begin
            r.busy_res = 1'b1;
            case (seq_phase)
                PH_CLK_HI, PH_ST1, PH_ST5, PH_WA_HI, PH_RB_HI: r.sck_level = 1'b1;
                PH_ST2, PH_ST4:
                begin
                    r.sck_level = 1'b1;
                    r.data_release = 1'b0;
                end
                PH_ST3: r.data_release = 1'b0;
                PH_WB_LO: r.data_release = shift_reg[7];
                PH_WB_HI:
                begin
                    r.sck_level = 1'b1;
                    r.data_release = shift_reg[7];
                end
                PH_RA_LO, PH_RA_END: r.data_release = on_last_byte();
                PH_RA_HI:
                begin
                    r.sck_level = 1'b1;
                    r.data_release = on_last_byte();
                end
                default: ;
            endcase
            if (seq_phase == PH_WAIT)
                seg_len = wait_ticks;
            else
                seg_len = half_ticks;
            next_count = seg_count + 1'b1;
            if (next_count >= seg_len)
            begin
                seg_count = '0;
                case (seq_phase)
                    PH_CLK_HI: seq_phase = PH_CLK_LO;
                    PH_CLK_LO:
                    begin
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= CLOCKS_CONN_RESET)
                        begin
                            bit_count = 4'd0;
                            seq_phase = PH_ST0;
                        end
                        else
                            seq_phase = PH_CLK_HI;
                    end
                    PH_ST0: seq_phase = PH_ST1;
                    PH_ST1: seq_phase = PH_ST2;
                    PH_ST2: seq_phase = PH_ST3;
                    PH_ST3: seq_phase = PH_ST4;
                    PH_ST4: seq_phase = PH_ST5;
                    PH_ST5:
                    begin
                        if (seq_op == OP_CONN_RESET)
                        begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            byte_count = 2'd0;
                            case (seq_op)
                                OP_TEMP:     load_write(CMD_TEMP);
                                OP_HUMID:    load_write(CMD_HUMID);
                                OP_STAT_RD:  load_write(CMD_STAT_RD);
                                OP_STAT_WR:  load_write(CMD_STAT_WR);
                                OP_SOFT_RST: load_write(CMD_SOFT);
                                default:     load_write(CMD_NONE);
                            endcase
                        end
                    end
                    PH_WB_LO: seq_phase = PH_WB_HI;
                    PH_WB_HI:
                    begin
                        shift_reg = {shift_reg[6:0], 1'b0};
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= BITS_PER_BYTE)
                            seq_phase = PH_WA_LO;
                        else
                            seq_phase = PH_WB_LO;
                    end
                    PH_WA_LO: seq_phase = PH_WA_HI;
                    PH_WA_HI:
                    begin
                        // released line at the acknowledge slot means no ack
                        if (t.data_level)
                            count_error();
                        if (seq_op == OP_STAT_WR && byte_count == 2'd0)
                        begin
                            byte_count = 2'd1;
                            load_write(word_reg[7:0]);
                        end
                        else if (seq_op == OP_TEMP || seq_op == OP_HUMID)
                            seq_phase = PH_WAIT;
                        else if (seq_op == OP_STAT_RD)
                        begin
                            byte_count = 2'd0;
                            load_read();
                        end
                        else
                        begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                    PH_WAIT:
                    begin
                        // conversion not finished in time
                        if (t.data_level)
                            count_error();
                        byte_count = 2'd0;
                        load_read();
                    end
                    PH_RB_LO: seq_phase = PH_RB_HI;
                    PH_RB_HI:
                    begin
                        shift_reg = {shift_reg[6:0], t.data_level};
                        bit_count = bit_count + 4'd1;
                        if (bit_count >= BITS_PER_BYTE)
                        begin
                            if (on_last_byte())
                                crc_reg = shift_reg;
                            else
                                word_reg = {word_reg[7:0], shift_reg};
                            seq_phase = PH_RA_LO;
                        end
                        else
                            seq_phase = PH_RB_LO;
                    end
                    PH_RA_LO: seq_phase = PH_RA_HI;
                    PH_RA_HI: seq_phase = PH_RA_END;
                    PH_RA_END:
                    begin
                        if (on_last_byte())
                        begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            byte_count = byte_count + 2'd1;
                            load_read();
                        end
                    end
                    default: seq_phase = PH_IDLE;
                endcase
            end
            else
                seg_count = next_count[WAIT_TIMER_BITS-1:0];
        end
        r.read_value = word_reg;
        r.checksum_byte = crc_reg;
        r.error_count = err_reg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got_v,
                                   input longint unsigned want_v);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     pins_checked, what, got_v, want_v);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                pin_forecast.push_back(step_sequencer(shown_tick));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() > 0 &&
                         !(tick_queue[0].drain_first && pin_forecast.size() != 0))
                begin
                    shown_tick = tick_queue.pop_front();
                    func <= shown_tick.func;
                    op <= shown_tick.op;
                    write_value <= shown_tick.write_value;
                    data_level <= shown_tick.data_level;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        gap_burst = !gap_burst;
                    gap_left = gap_burst ? 0 : $urandom_range(0, 7);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_pins = {sck_level, data_release, busy_res, done_res,
                             read_value, checksum_byte, error_count};
                pins_checked++;
                if (pin_forecast.size() == 0)
                    report_mismatch("result with nothing expected", seen_pins, 0);
                else
                begin
                    want_pins = pin_forecast.pop_front();
                    if (seen_pins.sck_level !== want_pins.sck_level)
                        report_mismatch("sck_level", seen_pins.sck_level, want_pins.sck_level);
                    if (seen_pins.data_release !== want_pins.data_release)
                        report_mismatch("data_release", seen_pins.data_release,
                                        want_pins.data_release);
                    if (seen_pins.busy_res !== want_pins.busy_res)
                        report_mismatch("busy_res", seen_pins.busy_res, want_pins.busy_res);
                    if (seen_pins.done_res !== want_pins.done_res)
                        report_mismatch("done_res", seen_pins.done_res, want_pins.done_res);
                    if (seen_pins.read_value !== want_pins.read_value)
                        report_mismatch("read_value", seen_pins.read_value,
                                        want_pins.read_value);
                    if (seen_pins.checksum_byte !== want_pins.checksum_byte)
                        report_mismatch("checksum_byte", seen_pins.checksum_byte,
                                        want_pins.checksum_byte);
                    if (seen_pins.error_count !== want_pins.error_count)
                        report_mismatch("error_count", seen_pins.error_count,
                                        want_pins.error_count);
                end
                if ($urandom_range(0, 31) == 0)
                    stall_burst = !stall_burst;
                stall_left = stall_burst ? 0 : $urandom_range(0, 7);
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic pick_level(input line_mode_t mode);
        if (mode == LINE_LOW)
            return 1'b0;
        if (mode == LINE_HIGH)
            return 1'b1;
        return 1'($urandom);
    endfunction

    task automatic queue_tick(input logic f, input logic [2:0] o, input logic [7:0] wv,
                              input logic d, input logic hold);
        tick_t t;
        t.func = f;
        t.op = o;
        t.write_value = wv;
        t.data_level = d;
        t.drain_first = hold;
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (pins_checked != ticks_queued)
            @(posedge clk);
    endtask

    // plain ticks until the sequencer is back in idle
    task automatic settle(input line_mode_t mode);
        wait_drained();
        while (seq_phase != PH_IDLE)
        begin
            repeat (8)
                queue_tick(1'b0, 3'($urandom), 8'($urandom), pick_level(mode), 1'b0);
            wait_drained();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_op(input logic [2:0] o, input logic [7:0] wv, input line_mode_t mode);
        queue_tick(1'b1, o, wv, pick_level(mode), 1'b0);
        // a second command while busy must be dropped; sent once the first result is in
        queue_tick(1'b1, OP_STAT_WR, ~wv, pick_level(mode), 1'b1);
        settle(mode);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HALF_PERIOD)
            half_ticks = value[HALF_BITS-1:0];
        else
            wait_ticks = value[WAIT_CFG_BITS-1:0];
    endtask

    task automatic set_timing(input logic [CFG_DATA_BITS-1:0] half,
                              input logic [CFG_DATA_BITS-1:0] wait_len);
        write_reg(REG_HALF_PERIOD, half);
        write_reg(REG_MEASURE_WAIT, wait_len);
    endtask

    task automatic random_ticks(input int count, input logic [5:0] allowed);
        logic [2:0] o;
        logic       f;
        logic       d;
        for (int i = 0; i < count; i++)
        begin
            o = 3'($urandom);
            f = ($urandom_range(0, 3) == 0);
            if (o <= OP_SOFT_RST && !allowed[o])
                f = 1'b0;
            // lean toward a sensor that pulls data low for acks and ready
            d = ($urandom_range(0, 2) == 0);
            queue_tick(f, o, 8'($urandom), d, $urandom_range(0, 99) == 0);
        end
        settle(LINE_RANDOM);
    endtask

    initial
    begin
        half_ticks = HALF_RESET;
        wait_ticks = WAIT_RESET;
        seq_phase = PH_IDLE;
        seq_op = OP_CONN_RESET;
        seg_count = '0;
        bit_count = 4'd0;
        byte_count = 2'd0;
        shift_reg = 8'h00;
        word_reg = 16'h0000;
        crc_reg = 8'h00;
        err_reg = 2'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing, no measurements under the long default wait
        queue_tick(1'b1, OP_SPARE_A, 8'hA5, 1'b0, 1'b0);
        queue_tick(1'b1, OP_SPARE_B, 8'h5A, 1'b1, 1'b0);
        run_op(OP_CONN_RESET, 8'h00, LINE_HIGH);
        run_op(OP_SOFT_RST, 8'h00, LINE_LOW);
        run_op(OP_STAT_RD, 8'h00, LINE_RANDOM);
        run_op(OP_STAT_WR, 8'hFF, LINE_HIGH);
        run_op(OP_STAT_WR, 8'h00, LINE_LOW);

        set_timing(24'd1, 24'd1);
        run_op(OP_TEMP, 8'h00, LINE_LOW);
        run_op(OP_HUMID, 8'hFF, LINE_HIGH);
        run_op(OP_TEMP, 8'h3C, LINE_RANDOM);
        run_op(OP_STAT_RD, 8'h00, LINE_HIGH);

        // zero lengths behave as one tick
        set_timing(24'd0, 24'd0);
        run_op(OP_HUMID, 8'h00, LINE_RANDOM);
        run_op(OP_SOFT_RST, 8'h00, LINE_HIGH);

        set_timing(24'd1, 24'($urandom_range(1, 8)));
        random_ticks(50, ALL_OPS);
        set_timing(24'd2, 24'($urandom_range(10, 60)));
        random_ticks(50, ALL_OPS);
        // upper data bits are dropped by the half period register
        set_timing({8'($urandom), 16'd1}, 24'($urandom_range(1, 20)));
        random_ticks(50, ALL_OPS);
        set_timing(24'd1, 24'hFFFFFF);
        random_ticks(40, NO_MEASURE);
        set_timing(24'h00FFFF, 24'd1);
        random_ticks(40, NO_OPS);
        set_timing(24'($urandom_range(1, 3)), 24'($urandom_range(1, 40)));
        random_ticks(50, ALL_OPS);
        set_timing(24'd0, 24'd0);
        random_ticks(50, ALL_OPS);

        repeat (16) @(posedge clk);
        if (pin_forecast.size() != 0)
            report_mismatch("results never arrived", pin_forecast.size(), 0);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
